FILE: src/fbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbt_pkg
// Shared types and constants of the flash resource busy-time table.
// ----------------------------------------------------------------------------
package fbt_pkg;

  localparam int TIME_W = 64;
  localparam int SPAN_W = 32;

  localparam int DEF_NUM_CHANNELS      = 8;
  localparam int DEF_CHIPS_PER_CHANNEL = 4;
  localparam int DEF_DIES_PER_CHIP     = 2;
  localparam int DEF_PLANES_PER_DIE    = 2;

  typedef enum logic {
    CMD_QUERY  = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_PROGRAM = 2'd1,
    KIND_ERASE   = 2'd2,
    KIND_OTHER   = 2'd3
  } kind_t;

endpackage : fbt_pkg
`default_nettype wire

FILE: src/flash_resource_busy_time_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flash_resource_busy_time_table
// Earliest-available-time tables for channels, chips, dies and planes.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries command words: tuser = {op_kind, cmd}; tdata holds the
//   address, now_time and busy_span. A query word yields one m_* word with
//   the latest busy time of the addressed chip, die and plane (and channel
//   for the "other" kind). An update word yields nothing; it raises the
//   same entries to now_time + busy_span (mod 2^64) where that is later.
//   Throughput is one word per cycle unless a query waits on a stalled
//   output. The tables are read at acceptance and the answer forms from
//   the stage register in the following cycle; the output register takes
//   it once it can accept, and m_tvalid comes from that register. An update
//   written in one cycle is seen by the word accepted in that same cycle
//   through forwarding in each table.
//   Reset clears every entry at once through per-entry valid bits; there
//   is no clearing sweep. When the receiver stalls, the output register
//   holds its word, a query in the stage register waits behind it, and
//   s_tready falls; updates never wait on the output.
// ----------------------------------------------------------------------------
module flash_resource_busy_time_table #(
  parameter int NUM_CHANNELS      = fbt_pkg::DEF_NUM_CHANNELS,
  parameter int CHIPS_PER_CHANNEL = fbt_pkg::DEF_CHIPS_PER_CHANNEL,
  parameter int DIES_PER_CHIP     = fbt_pkg::DEF_DIES_PER_CHIP,
  parameter int PLANES_PER_DIE    = fbt_pkg::DEF_PLANES_PER_DIE,
  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int CP_W   = (CHIPS_PER_CHANNEL > 1) ? $clog2(CHIPS_PER_CHANNEL) : 1,
  localparam int DI_W   = (DIES_PER_CHIP > 1) ? $clog2(DIES_PER_CHIP) : 1,
  localparam int PL_W   = (PLANES_PER_DIE > 1) ? $clog2(PLANES_PER_DIE) : 1,
  localparam int RAW_W  = CH_W + CP_W + DI_W + PL_W + fbt_pkg::TIME_W + fbt_pkg::SPAN_W,
  localparam int DATA_W = ((RAW_W + 7) / 8) * 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // fields from bit 0: channel, chip, die, plane, now_time, busy_span, zero pad
  input  wire logic [DATA_W-1:0]          s_tdata,
  // fields from bit 0: cmd, op_kind
  input  wire logic [2:0]                 s_tuser,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // fields from bit 0: available_time
  output logic      [fbt_pkg::TIME_W-1:0] m_tdata
);
  import fbt_pkg::*;

  localparam int N_CHIPS  = NUM_CHANNELS * CHIPS_PER_CHANNEL;
  localparam int N_DIES   = N_CHIPS * DIES_PER_CHIP;
  localparam int N_PLANES = N_DIES * PLANES_PER_DIE;
  localparam int CI_W  = (N_CHIPS > 1) ? $clog2(N_CHIPS) : 1;
  localparam int DX_W  = (N_DIES > 1) ? $clog2(N_DIES) : 1;
  localparam int PX_W  = (N_PLANES > 1) ? $clog2(N_PLANES) : 1;
  localparam int CIF_W = CH_W + CP_W;
  localparam int DXF_W = CIF_W + DI_W;
  localparam int PXF_W = DXF_W + PL_W;

  localparam int CP_LO  = CH_W;
  localparam int DI_LO  = CP_LO + CP_W;
  localparam int PL_LO  = DI_LO + DI_W;
  localparam int NOW_LO = PL_LO + PL_W;
  localparam int SPN_LO = NOW_LO + TIME_W;

  // input unpack
  logic [CH_W-1:0]   in_ch;
  logic [CP_W-1:0]   in_cp;
  logic [DI_W-1:0]   in_di;
  logic [PL_W-1:0]   in_pl;
  logic [TIME_W-1:0] in_now;
  logic [SPAN_W-1:0] in_span;
  logic [CIF_W-1:0]  in_ci;
  logic [DXF_W-1:0]  in_dx;
  logic [PXF_W-1:0]  in_px;
  logic              in_ch_ok;
  logic              in_cp_ok;
  logic              in_di_ok;
  logic              in_pl_ok;
  logic              accept;

  // stage register
  logic              s1_valid;
  cmd_t              s1_cmd;
  kind_t             s1_kind;
  logic              s1_ch_ok;
  logic              s1_cp_ok;
  logic              s1_di_ok;
  logic              s1_pl_ok;
  logic [TIME_W-1:0] s1_t;
  logic [CH_W-1:0]   s1_ch;
  logic [CI_W-1:0]   s1_ci;
  logic [DX_W-1:0]   s1_dx;
  logic [PX_W-1:0]   s1_px;
  logic              s1_adv;

  logic [TIME_W-1:0] ch_rd, cp_rd, di_rd, pl_rd;
  logic              ch_we, cp_we, di_we, pl_we;
  logic              s1_upd;
  logic [TIME_W-1:0] q_ch, q_cp, q_di, q_pl, m01, m23, q_best;
  logic              res_valid;
  logic              res_ready;

  assign in_ch   = s_tdata[CH_W-1:0];
  assign in_cp   = s_tdata[CP_LO +: CP_W];
  assign in_di   = s_tdata[DI_LO +: DI_W];
  assign in_pl   = s_tdata[PL_LO +: PL_W];
  assign in_now  = s_tdata[NOW_LO +: TIME_W];
  assign in_span = s_tdata[SPN_LO +: SPAN_W];

  assign in_ci = CIF_W'(in_ch) * CIF_W'(CHIPS_PER_CHANNEL) + CIF_W'(in_cp);
  assign in_dx = DXF_W'(in_ci) * DXF_W'(DIES_PER_CHIP) + DXF_W'(in_di);
  assign in_px = PXF_W'(in_dx) * PXF_W'(PLANES_PER_DIE) + PXF_W'(in_pl);

  assign in_ch_ok = 32'(in_ch) < NUM_CHANNELS;
  assign in_cp_ok = in_ch_ok && (32'(in_cp) < CHIPS_PER_CHANNEL);
  assign in_di_ok = in_cp_ok && (32'(in_di) < DIES_PER_CHIP);
  assign in_pl_ok = in_di_ok && (32'(in_pl) < PLANES_PER_DIE);

  assign s1_upd   = s1_valid && (s1_cmd == CMD_UPDATE);
  assign s1_adv   = !s1_valid || (s1_cmd == CMD_UPDATE) || res_ready;
  assign s_tready = s1_adv;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd   <= cmd_t'(s_tuser[0]);
      s1_kind  <= kind_t'(s_tuser[2:1]);
      s1_ch_ok <= in_ch_ok;
      s1_cp_ok <= in_cp_ok;
      s1_di_ok <= in_di_ok;
      s1_pl_ok <= in_pl_ok;
      s1_t     <= in_now + TIME_W'(in_span);
      s1_ch    <= in_ch;
      s1_ci    <= in_ci[CI_W-1:0];
      s1_dx    <= in_dx[DX_W-1:0];
      s1_px    <= in_px[PX_W-1:0];
    end
  end

  // raise only where the new end time is later; the whole update drops if
  // any index is beyond the array
  assign ch_we = s1_upd && s1_pl_ok && (s1_kind == KIND_OTHER) && (s1_t > ch_rd);
  assign cp_we = s1_upd && s1_pl_ok && (s1_t > cp_rd);
  assign di_we = s1_upd && s1_pl_ok && (s1_t > di_rd);
  assign pl_we = s1_upd && s1_pl_ok && (s1_t > pl_rd);

  fbt_table #(.DEPTH(NUM_CHANNELS)) u_ch_tbl (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_ch),
    .rd_data (ch_rd),
    .wr_en   (ch_we),
    .wr_addr (s1_ch),
    .wr_data (s1_t)
  );

  fbt_table #(.DEPTH(N_CHIPS)) u_cp_tbl (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_ci[CI_W-1:0]),
    .rd_data (cp_rd),
    .wr_en   (cp_we),
    .wr_addr (s1_ci),
    .wr_data (s1_t)
  );

  fbt_table #(.DEPTH(N_DIES)) u_di_tbl (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_dx[DX_W-1:0]),
    .rd_data (di_rd),
    .wr_en   (di_we),
    .wr_addr (s1_dx),
    .wr_data (s1_t)
  );

  fbt_table #(.DEPTH(N_PLANES)) u_pl_tbl (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_px[PX_W-1:0]),
    .rd_data (pl_rd),
    .wr_en   (pl_we),
    .wr_addr (s1_px),
    .wr_data (s1_t)
  );

  // read, program and erase leave the channel out of the answer
  assign q_ch   = ((s1_kind == KIND_OTHER) && s1_ch_ok) ? ch_rd : '0;
  assign q_cp   = s1_cp_ok ? cp_rd : '0;
  assign q_di   = s1_di_ok ? di_rd : '0;
  assign q_pl   = s1_pl_ok ? pl_rd : '0;
  assign m01    = (q_ch > q_cp) ? q_ch : q_cp;
  assign m23    = (q_di > q_pl) ? q_di : q_pl;
  assign q_best = (m01 > m23) ? m01 : m23;

  assign res_valid = s1_valid && (s1_cmd == CMD_QUERY);

  fbt_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_ready (res_ready),
    .in_data  (q_best),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_update_no_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && (s1_cmd == CMD_UPDATE) |-> s_tready)
    else $error("flash_resource_busy_time_table: update held by output stall");

  a_query_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && s1_valid && !s1_adv |=> s1_valid && $stable(s1_px) && $stable(s1_kind))
    else $error("flash_resource_busy_time_table: stalled query lost");

  a_query_result: assert property (@(posedge clk) disable iff (rst)
    !rst && s1_valid && (s1_cmd == CMD_QUERY) && s1_adv |=> m_tvalid)
    else $error("flash_resource_busy_time_table: query left without a result");

endmodule : flash_resource_busy_time_table
`default_nettype wire

FILE: src/fbt_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbt_table
// One busy-time store: memory with per-entry valid bits, registered read
// and write-to-read forwarding for a write and read in the same cycle.
// ----------------------------------------------------------------------------
module fbt_table #(
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      rd_en,
  input  wire logic [AW-1:0]             rd_addr,
  output logic      [fbt_pkg::TIME_W-1:0] rd_data,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [fbt_pkg::TIME_W-1:0] wr_data
);
  import fbt_pkg::*;

  logic [TIME_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [TIME_W-1:0] rd_q;
  logic [TIME_W-1:0] fwd_data;
  logic              fwd_hit;
  logic              rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      fwd_hit <= 1'b0;
      rd_vld  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        // catch the word written in the same cycle
        fwd_hit <= wr_en && (wr_addr == rd_addr);
        rd_vld  <= valid[rd_addr];
      end
    end
  end

  // never-written entries read as zero
  assign rd_data = fwd_hit ? fwd_data : (rd_vld ? rd_q : '0);

  a_forward: assert property (@(posedge clk) disable iff (rst)
    !rst && rd_en && wr_en && (rd_addr == wr_addr) |=> rd_data == $past(wr_data))
    else $error("fbt_table: same-cycle write not forwarded");

  a_valid_set: assert property (@(posedge clk) disable iff (rst)
    !rst && wr_en |=> valid[$past(wr_addr)])
    else $error("fbt_table: written entry not marked valid");

  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && !rd_en |=> rd_data == $past(rd_data))
    else $error("fbt_table: read data moved without a read");

endmodule : fbt_table
`default_nettype wire

FILE: src/fbt_out.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbt_out
// Output register of the result stream.
// ----------------------------------------------------------------------------
module fbt_out (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [fbt_pkg::TIME_W-1:0] in_data,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic      [fbt_pkg::TIME_W-1:0] m_tdata    // available_time
);
  import fbt_pkg::*;

  assign in_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      m_tdata <= in_data;
    end
  end

endmodule : fbt_out
`default_nettype wire
